@@ src/bqlpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlpf_pkg
// Shared types and constants of the biquad low-pass filter unit.
// ----------------------------------------------------------------------------
package bqlpf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 18;
  localparam int unsigned StateW  = 32;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] REG_B0    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_B1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_B2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_A1    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_A2    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCALE = 3'd5;

  localparam logic [ScaleW-1:0] SCALE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    KIND_FILTER = 2'd0,
    KIND_PRIME  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_PRIME_WR,
    ST_A1,
    ST_A2,
    ST_W1,
    ST_W2,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_Y1,
    ST_Y2,
    ST_CLEAR,
    ST_NULL
  } state_e;

  typedef enum logic [2:0] {
    MS_PRIME,
    MS_D1A1,
    MS_D2A2,
    MS_WB0,
    MS_D1B1,
    MS_D2B2
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_LOAD_P,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    mul_sel_e   mul_sel;
    acc_op_e    acc_op;
    logic       load_in;
    logic       prime_load;
    logic       w_load;
    logic       out_load;
    logic       out_zero;
    logic       clear_state;
    logic       shift_state;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage : bqlpf_pkg
`default_nettype wire

@@ src/biquad_lowpass_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_lowpass_filter_unit
// Direct form II second-order low-pass biquad on signed 16-bit samples.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A filter transaction steps through
// states A1, A2, W1, W2, B0, B1, B2, Y1 and Y2 before its result is loaded
// into the output register, a prime transaction runs PRIME and PRIME_WR
// first, and a clear or unused transaction loads its zero result from its
// own state; the next input is accepted in the cycle after the load. The
// single shared 33x18 multiplier forms the five products of a filter
// transaction (six with priming) one per cycle, with the accumulate and
// rounding steps alongside them. A finished result waits in the output
// register while the next transaction is accepted and worked on; a further
// result stalls the block until the output register is free.
// Coefficients are signed Q2.16, delays Q24.8, prime_scale unsigned Q16.16;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter_unit
  import bqlpf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,   // [15:0] sample
  input  wire logic [1:0]         s_axis_tuser,   // [1:0] kind
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [15:0] filtered
  output logic [0:0]              m_axis_tuser    // [0] substituted
);

  cmd_t    cmd;
  status_t status;

  bqlpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (kind_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bqlpf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_sample_i    (s_axis_tdata),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_filtered_o (m_axis_tdata),
    .out_subst_o    (m_axis_tuser[0])
  );

  // one transaction in flight: no second acceptance right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an unconsumed result");

  // the delay shift belongs to the cycle that loads a filter result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift_state |-> (cmd.out_load && !cmd.out_zero))
    else $error("delay shift without a filter result");

  // state updates never collide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear_state, cmd.prime_load, cmd.shift_state, cmd.w_load}))
    else $error("conflicting state updates");

endmodule : biquad_lowpass_filter_unit
`default_nettype wire

@@ src/bqlpf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlpf_ctrl
// Sequencer that steps the shared multiplier and accumulator through one item.
// ----------------------------------------------------------------------------
module bqlpf_ctrl
  import bqlpf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire kind_e   in_kind_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_kind_i)
            KIND_FILTER: state_d = ST_A1;
            KIND_PRIME:  state_d = ST_PRIME;
            KIND_CLEAR:  state_d = ST_CLEAR;
            KIND_NONE:   state_d = ST_NULL;
            default:     state_d = ST_NULL;
          endcase
        end
      end
      ST_PRIME:    state_d = ST_PRIME_WR;
      ST_PRIME_WR: state_d = ST_A1;
      ST_A1:       state_d = ST_A2;
      ST_A2:       state_d = ST_W1;
      ST_W1:       state_d = ST_W2;
      ST_W2:       state_d = ST_B0;
      ST_B0:       state_d = ST_B1;
      ST_B1:       state_d = ST_B2;
      ST_B2:       state_d = ST_Y1;
      ST_Y1:       state_d = ST_Y2;
      ST_Y2, ST_CLEAR, ST_NULL: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MS_PRIME;
    cmd_o.acc_op  = ACC_HOLD;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_PRIME:    cmd_o.mul_sel = MS_PRIME;
      ST_PRIME_WR: cmd_o.prime_load = 1'b1;
      ST_A1: begin
        cmd_o.mul_sel = MS_D1A1;
        cmd_o.acc_op  = ACC_LOAD_X;
      end
      ST_A2: begin
        cmd_o.mul_sel = MS_D2A2;
        cmd_o.acc_op  = ACC_SUB;
      end
      ST_W1:       cmd_o.acc_op = ACC_SUB;
      ST_W2:       cmd_o.w_load = 1'b1;
      ST_B0:       cmd_o.mul_sel = MS_WB0;
      ST_B1: begin
        cmd_o.mul_sel = MS_D1B1;
        cmd_o.acc_op  = ACC_LOAD_P;
      end
      ST_B2: begin
        cmd_o.mul_sel = MS_D2B2;
        cmd_o.acc_op  = ACC_ADD;
      end
      ST_Y1:       cmd_o.acc_op = ACC_ADD;
      ST_Y2: begin
        cmd_o.out_load    = status_i.out_free;
        cmd_o.shift_state = status_i.out_free;
      end
      ST_CLEAR: begin
        cmd_o.out_load    = status_i.out_free;
        cmd_o.out_zero    = 1'b1;
        cmd_o.clear_state = status_i.out_free;
      end
      ST_NULL: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_zero = 1'b1;
      end
      default: begin
        cmd_o.acc_op = ACC_HOLD;
      end
    endcase
  end

endmodule : bqlpf_ctrl
`default_nettype wire

@@ src/bqlpf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlpf_datapath
// Coefficient registers, delay state, shared multiplier, accumulator and
// output register of the biquad.
// ----------------------------------------------------------------------------
module bqlpf_datapath
  import bqlpf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic [SampleW-1:0] in_sample_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [SampleW-1:0]      out_filtered_o,
  output logic                    out_subst_o
);

  localparam int unsigned MulAW  = StateW + 1;
  localparam int unsigned ProdW  = MulAW + CoefW;
  localparam int unsigned AccW   = ProdW + 2;

  logic signed [CoefW-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
  logic        [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q    <= '0;
      b1_q    <= '0;
      b2_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_B0:    b0_q    <= cfg_data_i[CoefW-1:0];
        REG_B1:    b1_q    <= cfg_data_i[CoefW-1:0];
        REG_B2:    b2_q    <= cfg_data_i[CoefW-1:0];
        REG_A1:    a1_q    <= cfg_data_i[CoefW-1:0];
        REG_A2:    a2_q    <= cfg_data_i[CoefW-1:0];
        REG_SCALE: scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [SampleW-1:0] x_q;
  logic signed [StateW-1:0]  d1_q, d2_q, w_q, w_d, prime_d;
  logic                      subst_q, subst_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [CoefW-1:0]   mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= in_sample_i;
    end
  end

  // one shared 33x18 signed multiplier, product registered
  always_comb begin
    mul_a = {{(MulAW-StateW){d1_q[StateW-1]}}, d1_q};
    mul_b = a1_q;
    unique case (cmd_i.mul_sel)
      MS_PRIME: begin
        mul_a = {1'b0, scale_q};
        mul_b = {{(CoefW-SampleW){x_q[SampleW-1]}}, x_q};
      end
      MS_D1A1: begin
        mul_a = {{(MulAW-StateW){d1_q[StateW-1]}}, d1_q};
        mul_b = a1_q;
      end
      MS_D2A2: begin
        mul_a = {{(MulAW-StateW){d2_q[StateW-1]}}, d2_q};
        mul_b = a2_q;
      end
      MS_WB0: begin
        mul_a = {{(MulAW-StateW){w_q[StateW-1]}}, w_q};
        mul_b = b0_q;
      end
      MS_D1B1: begin
        mul_a = {{(MulAW-StateW){d1_q[StateW-1]}}, d1_q};
        mul_b = b1_q;
      end
      MS_D2B2: begin
        mul_a = {{(MulAW-StateW){d2_q[StateW-1]}}, d2_q};
        mul_b = b2_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  logic signed [AccW-1:0] x_acc, prod_ext;
  assign x_acc    = {{(AccW-SampleW-24){x_q[SampleW-1]}}, x_q, 24'd0};
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.acc_op)
      ACC_HOLD:   acc_d = acc_q;
      ACC_LOAD_X: acc_d = x_acc;
      ACC_SUB:    acc_d = acc_q - prod_ext;
      ACC_LOAD_P: acc_d = prod_ext;
      ACC_ADD:    acc_d = acc_q + prod_ext;
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // prime value: round Q.16 product to Q24.8, saturate to state width
  logic signed [ProdW-1:0] p_shr;
  logic                    p_fits;
  assign p_shr  = (prod_q + ProdW'(128)) >>> 8;
  assign p_fits = (&p_shr[ProdW-1:StateW-1]) | ~(|p_shr[ProdW-1:StateW-1]);
  assign prime_d = p_fits ? p_shr[StateW-1:0]
                          : (p_shr[ProdW-1] ? {1'b1, {(StateW-1){1'b0}}}
                                            : {1'b0, {(StateW-1){1'b1}}});

  // new delay value; falls back to the sample when out of state range
  logic signed [AccW-1:0] w_shr;
  logic                   w_fits;
  assign w_shr   = (acc_q + AccW'(32768)) >>> 16;
  assign w_fits  = (&w_shr[AccW-1:StateW-1]) | ~(|w_shr[AccW-1:StateW-1]);
  assign w_d     = w_fits ? w_shr[StateW-1:0]
                          : {{(StateW-SampleW-8){x_q[SampleW-1]}}, x_q, 8'd0};
  assign subst_d = ~w_fits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_load) begin
      w_q     <= w_d;
      subst_q <= subst_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.clear_state) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.prime_load) begin
      d1_q <= prime_d;
      d2_q <= prime_d;
    end else if (cmd_i.shift_state) begin
      d1_q <= w_q;
      d2_q <= d1_q;
    end
  end

  // output: round Q.24 to integer, saturate to sample range
  logic signed [AccW-1:0]    y_shr;
  logic                      y_fits;
  logic signed [SampleW-1:0] y_sat;
  assign y_shr  = (acc_q + AccW'(8388608)) >>> 24;
  assign y_fits = (&y_shr[AccW-1:SampleW-1]) | ~(|y_shr[AccW-1:SampleW-1]);
  assign y_sat  = y_fits ? y_shr[SampleW-1:0]
                         : (y_shr[AccW-1] ? {1'b1, {(SampleW-1){1'b0}}}
                                          : {1'b0, {(SampleW-1){1'b1}}});

  logic                 out_valid_q;
  logic [SampleW-1:0]   out_filtered_q;
  logic                 out_subst_q;

  assign status_o.out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_filtered_q <= cmd_i.out_zero ? '0 : y_sat;
      out_subst_q    <= cmd_i.out_zero ? 1'b0 : subst_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_filtered_o = out_filtered_q;
  assign out_subst_o    = out_subst_q;

endmodule : bqlpf_datapath
`default_nettype wire
